[design/spectrogram_box_smoother_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the spectrogram box smoother
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPECTROGRAM_BOX_SMOOTHER_TOP_ASSERT_SVH
`define SPECTROGRAM_BOX_SMOOTHER_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrogram box smoother package
// Sizes, arithmetic constants and the column entry passed front to back.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int MAX_BANDS  = 512;
    localparam int TIME_DEPTH = 5;
    localparam int FREQ_WIDTH = 5;
    localparam int HALF       = FREQ_WIDTH / 2;
    localparam int WIN        = 2 * HALF + 1;
    localparam int DIVISOR    = TIME_DEPTH * FREQ_WIDTH;
    localparam int ROUND      = DIVISOR / 2;

    localparam int LEVEL_W = 15;
    localparam int BAND_W  = $clog2(MAX_BANDS);
    localparam int CFG_W   = 10;
    localparam int ROW_W   = $clog2(TIME_DEPTH);
    localparam int COL_W   = 18;
    localparam int SUM_W   = 20;
    localparam int MASK_W  = HALF + 1;
    localparam int PH_W    = $clog2(HALF + 1);

    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = 21;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [BAND_W-1:0] band;
        logic              last;
    } sbs_col_t;

endpackage
`default_nettype wire

[design/sbs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrogram box smoother front end
// Accepts band levels, tracks band and row, writes the five row banks and
// forms the time sum of each band column for the queue.
// ----------------------------------------------------------------------------
module sbs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbs_pkg::CFG_W-1:0]    active_bands,
    input  logic                         level_valid,
    output logic                         level_stall,
    input  logic [sbs_pkg::LEVEL_W-1:0]  level,
    input  logic [sbs_pkg::QCNT_W-1:0]   q_count,
    output logic                         push,
    output sbs_pkg::sbs_col_t            push_entry
);
    import sbs_pkg::*;

    logic [CFG_W-1:0]   active_bands_reg, active_bands_next;
    logic [BAND_W-1:0]  band_count_reg, band_count_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CFG_W-1:0]   fill_reg [TIME_DEPTH];
    logic [CFG_W-1:0]   fill_next [TIME_DEPTH];

    logic                  fa_valid_reg;
    logic [LEVEL_W-1:0]    fa_level_reg;
    logic [BAND_W-1:0]     fa_band_reg;
    logic                  fa_last_reg;
    logic [ROW_W-1:0]      fa_row_reg;
    logic [TIME_DEPTH-1:0] fa_live_reg;

    logic                  accept;
    logic [CFG_W-1:0]      eff_bands;
    logic [CFG_W-1:0]      band_inc;
    logic                  last;
    logic [TIME_DEPTH-1:0] live;
    logic [QCNT_W:0]       occupancy;
    logic [LEVEL_W-1:0]    rd_word [TIME_DEPTH];
    logic [COL_W-1:0]      col;

    assign cfg_ready = 1'b1;
    assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(fa_valid_reg);
    assign level_stall = occupancy >= (QCNT_W+1)'(QDEPTH);
    assign accept = level_valid && !level_stall;

    always_comb
    begin
        if (active_bands_reg == '0)
            eff_bands = CFG_W'(1);
        else if (active_bands_reg > CFG_W'(MAX_BANDS))
            eff_bands = CFG_W'(MAX_BANDS);
        else
            eff_bands = active_bands_reg;
        band_inc = CFG_W'(band_count_reg) + CFG_W'(1);
        last = band_inc >= eff_bands;
        for (int t = 0; t < TIME_DEPTH; t++)
            live[t] = CFG_W'(band_count_reg) < fill_reg[t];
    end

    always_comb
    begin
        active_bands_next = cfg_valid ? active_bands : active_bands_reg;
        band_count_next = band_count_reg;
        row_next = row_reg;
        for (int t = 0; t < TIME_DEPTH; t++)
            fill_next[t] = fill_reg[t];
        if (accept)
        begin
            if (last)
            begin
                band_count_next = '0;
                row_next = (row_reg == ROW_W'(TIME_DEPTH - 1)) ? '0 : row_reg + 1'b1;
            end
            else
                band_count_next = band_inc[BAND_W-1:0];
            for (int t = 0; t < TIME_DEPTH; t++)
                if (row_reg == ROW_W'(t) && band_inc > fill_reg[t])
                    fill_next[t] = band_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bands_reg <= CFG_W'(MAX_BANDS);
            band_count_reg   <= '0;
            row_reg          <= '0;
            fa_valid_reg     <= 1'b0;
            for (int t = 0; t < TIME_DEPTH; t++)
                fill_reg[t] <= '0;
        end
        else
        begin
            active_bands_reg <= active_bands_next;
            band_count_reg   <= band_count_next;
            row_reg          <= row_next;
            fa_valid_reg     <= accept;
            for (int t = 0; t < TIME_DEPTH; t++)
                fill_reg[t] <= fill_next[t];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fa_level_reg <= level;
            fa_band_reg  <= band_count_reg;
            fa_last_reg  <= last;
            fa_row_reg   <= row_reg;
            fa_live_reg  <= live;
        end
    end

    for (genvar t = 0; t < TIME_DEPTH; t++)
    begin : g_bank
        logic [LEVEL_W-1:0] bank_mem [MAX_BANDS];
        logic [LEVEL_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (accept && row_reg == ROW_W'(t))
                bank_mem[band_count_reg] <= level;
            if (accept)
                rd_reg <= bank_mem[band_count_reg];
        end

        assign rd_word[t] = rd_reg;
    end

    // substitute the fresh level for the row being overwritten
    always_comb
    begin
        col = '0;
        for (int t = 0; t < TIME_DEPTH; t++)
        begin
            if (fa_row_reg == ROW_W'(t))
                col = col + COL_W'(fa_level_reg);
            else if (fa_live_reg[t])
                col = col + COL_W'(rd_word[t]);
        end
    end

    assign push = fa_valid_reg;
    assign push_entry = '{col: col, band: fa_band_reg, last: fa_last_reg};

endmodule
`default_nettype wire

[design/sbs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "spectrogram_box_smoother_top_assert.svh"
// ----------------------------------------------------------------------------
// Spectrogram box smoother column queue
// Short FIFO of column entries between the front end and the back end.
// ----------------------------------------------------------------------------
module sbs_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  sbs_pkg::sbs_col_t          push_entry,
    input  logic                       pop,
    output sbs_pkg::sbs_col_t          pop_entry,
    output logic                       nonempty,
    output logic [sbs_pkg::QCNT_W-1:0] count
);
    import sbs_pkg::*;

    sbs_col_t            store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

    assign pop_entry = store_reg[rd_ptr_reg];
    assign nonempty  = count_reg != '0;
    assign count     = count_reg;

    `SBS_ASSERT_SAME(a_no_overflow, push && !pop, count_reg != QCNT_W'(QDEPTH), "queue overflow")
    `SBS_ASSERT_NEXT(a_push_lands, push, count_reg != '0, "pushed entry lost")

endmodule
`default_nettype wire

[design/sbs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "spectrogram_box_smoother_top_assert.svh"
// ----------------------------------------------------------------------------
// Spectrogram box smoother back end
// Slides the column window, sequences up to three results per column,
// divides by the box area and tracks the frame maximum.
// ----------------------------------------------------------------------------
module sbs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_nonempty,
    input  sbs_pkg::sbs_col_t            q_entry,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [sbs_pkg::BAND_W-1:0]   band,
    output logic [sbs_pkg::LEVEL_W-1:0]  smoothed,
    output logic [sbs_pkg::LEVEL_W-1:0]  frame_max,
    output logic                         last_of_frame
);
    import sbs_pkg::*;

    logic [COL_W-1:0]   cs_reg [WIN];
    logic [COL_W-1:0]   cs_next [WIN];
    logic               s1_valid_reg, s1_valid_next;
    logic [MASK_W-1:0]  s1_mask_reg, s1_mask_next;
    logic [BAND_W-1:0]  s1_band_reg, s1_band_next;
    logic               first_pend_reg, first_pend_next;

    logic               p2_valid_reg;
    logic [SUM_W-1:0]   p2_sum_reg;
    logic [BAND_W-1:0]  p2_band_reg;
    logic               p2_last_reg;
    logic               p2_first_reg;

    logic               p3_valid_reg;
    logic [PROD_W-1:0]  p3_prod_reg;
    logic [BAND_W-1:0]  p3_band_reg;
    logic               p3_last_reg;
    logic               p3_first_reg;

    logic               result_valid_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [LEVEL_W-1:0] smoothed_reg;
    logic               last_reg;
    logic [LEVEL_W-1:0] running_max_reg, running_max_next;

    logic               out_ready, p3_ready, p2_ready, emit, done;
    logic [PH_W-1:0]    sel_phase;
    logic [MASK_W-1:0]  mask_after, new_mask;
    logic [SUM_W-1:0]   win_sum;
    logic [BAND_W-1:0]  emit_band;
    logic               emit_last;
    logic               entry_first;
    logic [QUO_W-1:0]   quotient;
    logic [LEVEL_W-1:0] val;
    logic [LEVEL_W-1:0] max_base;

    assign out_ready = !result_valid_reg || !result_stall;
    assign p3_ready  = !p3_valid_reg || out_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign emit      = s1_valid_reg && p2_ready;

    always_comb
    begin
        sel_phase = '0;
        for (int p = HALF; p >= 0; p--)
            if (s1_mask_reg[p])
                sel_phase = PH_W'(p);
        mask_after = s1_mask_reg & ~(MASK_W'(1) << sel_phase);
        done = mask_after == '0;
        emit_band = s1_band_reg - BAND_W'(HALF) + BAND_W'(sel_phase);
        emit_last = sel_phase == PH_W'(HALF);
        win_sum = SUM_W'(ROUND);
        for (int j = 0; j < WIN; j++)
            if (j <= WIN - 1 - int'(sel_phase))
                win_sum = win_sum + SUM_W'(cs_reg[j]);
    end

    assign pop = q_nonempty && (!s1_valid_reg || (emit && done));
    assign entry_first = q_entry.band == '0;

    always_comb
    begin
        for (int p = 0; p <= HALF; p++)
            new_mask[p] = (p == 0 || q_entry.last) && (int'(q_entry.band) + p >= HALF);
    end

    always_comb
    begin
        for (int j = 0; j < WIN; j++)
            cs_next[j] = cs_reg[j];
        s1_valid_next = s1_valid_reg;
        s1_mask_next  = s1_mask_reg;
        s1_band_next  = s1_band_reg;
        if (emit)
        begin
            s1_mask_next  = mask_after;
            s1_valid_next = !done;
        end
        if (pop)
        begin
            cs_next[0] = q_entry.col;
            for (int j = 1; j < WIN; j++)
                cs_next[j] = entry_first ? '0 : cs_reg[j-1];
            s1_valid_next = new_mask != '0;
            s1_mask_next  = new_mask;
            s1_band_next  = q_entry.band;
        end
        if (pop && entry_first)
            first_pend_next = 1'b1;
        else if (emit)
            first_pend_next = 1'b0;
        else
            first_pend_next = first_pend_reg;
    end

    assign quotient = p3_prod_reg[PROD_W-1:RECIP_SHIFT];
    assign val = (quotient > QUO_W'(LEVEL_MAX)) ? LEVEL_MAX : quotient[LEVEL_W-1:0];
    assign max_base = p3_first_reg ? '0 : running_max_reg;

    always_comb
    begin
        running_max_next = running_max_reg;
        if (p3_valid_reg && out_ready)
            running_max_next = (val > max_base) ? val : max_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WIN; j++)
                cs_reg[j] <= '0;
            s1_valid_reg     <= 1'b0;
            s1_mask_reg      <= '0;
            first_pend_reg   <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            running_max_reg  <= '0;
        end
        else
        begin
            for (int j = 0; j < WIN; j++)
                cs_reg[j] <= cs_next[j];
            s1_valid_reg   <= s1_valid_next;
            s1_mask_reg    <= s1_mask_next;
            first_pend_reg <= first_pend_next;
            if (p2_ready)
                p2_valid_reg <= emit;
            if (p3_ready)
                p3_valid_reg <= p2_valid_reg;
            if (out_ready)
                result_valid_reg <= p3_valid_reg;
            running_max_reg <= running_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_band_reg <= s1_band_next;
        if (p2_ready && emit)
        begin
            p2_sum_reg   <= win_sum;
            p2_band_reg  <= emit_band;
            p2_last_reg  <= emit_last;
            p2_first_reg <= first_pend_reg;
        end
        if (p3_ready && p2_valid_reg)
        begin
            p3_prod_reg  <= PROD_W'(p2_sum_reg) * PROD_W'(RECIP);
            p3_band_reg  <= p2_band_reg;
            p3_last_reg  <= p2_last_reg;
            p3_first_reg <= p2_first_reg;
        end
        if (out_ready && p3_valid_reg)
        begin
            band_reg     <= p3_band_reg;
            smoothed_reg <= val;
            last_reg     <= p3_last_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign band          = band_reg;
    assign smoothed      = smoothed_reg;
    assign frame_max     = running_max_reg;
    assign last_of_frame = last_reg;

    `SBS_ASSERT_SAME(a_pending_nonzero, s1_valid_reg, s1_mask_reg != '0, "empty result mask held")
    `SBS_ASSERT_SAME(a_quotient_fits, p3_valid_reg, quotient <= QUO_W'(LEVEL_MAX), "quotient overflow")
    `SBS_ASSERT_SAME(a_max_covers, result_valid_reg, running_max_reg >= smoothed_reg, "max below value")

endmodule
`default_nettype wire

[design/spectrogram_box_smoother_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrogram box smoother
// 5 x 5 moving average over time and frequency of spectrogram band levels.
// ----------------------------------------------------------------------------
// Usage: band levels are taken one per cycle while level_stall is low, lowest
// band first; the five stored frames sit in five row banks that are all read
// together at the incoming band, so column sums keep pace with the input.
// Each band gives one result two bands later; bands 0 and 1 give none unless
// last, and the last band gives up to three (the top two flushed). The back
// end spends longer on the last band than on the others, so a single frame
// streams in at one level per cycle through the four-entry column queue
// unless result_stall holds the output, while frames sent back to back make
// the input stall when the queue fills. A level passes the front-end register,
// the column queue, the window register, the sum and product registers and
// the output register on its way to its result. The store reads as zero
// after reset through per-row fill marks, so there is no clearing pass and
// levels are accepted from the first cycle. frame_max on the result flagged
// last_of_frame is the largest smoothed value of that frame. Write
// active_bands only while the block is idle.
// ----------------------------------------------------------------------------
module spectrogram_box_smoother_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbs_pkg::CFG_W-1:0]    active_bands,
    input  logic                         level_valid,
    output logic                         level_stall,
    input  logic [sbs_pkg::LEVEL_W-1:0]  level,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [sbs_pkg::BAND_W-1:0]   band,
    output logic [sbs_pkg::LEVEL_W-1:0]  smoothed,
    output logic [sbs_pkg::LEVEL_W-1:0]  frame_max,
    output logic                         last_of_frame
);
    import sbs_pkg::*;

    logic              push;
    sbs_col_t          push_entry;
    logic              pop;
    sbs_col_t          pop_entry;
    logic              q_nonempty;
    logic [QCNT_W-1:0] q_count;

    sbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .active_bands (active_bands),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .level        (level),
        .q_count      (q_count),
        .push         (push),
        .push_entry   (push_entry)
    );

    sbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .nonempty   (q_nonempty),
        .count      (q_count)
    );

    sbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_nonempty    (q_nonempty),
        .q_entry       (pop_entry),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .band          (band),
        .smoothed      (smoothed),
        .frame_max     (frame_max),
        .last_of_frame (last_of_frame)
    );

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrogram box smoother testbench
// Streams band levels through the block with random gaps on both sides and
// a scoreboard that predicts each smoothed band, its frame maximum and the
// end-of-frame flag. The active band count is changed between frames, twice
// mid frame, and through its extremes; one long frame runs with a long
// output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import sbs_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_BANDS    = 48;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] smoothed;
        logic [LEVEL_W-1:0] frame_max;
        logic               last;
    } band_result_t;

    class smoother_scoreboard;
        logic [LEVEL_W-1:0] rows [TIME_DEPTH][MAX_BANDS];
        int unsigned        write_row;
        int unsigned        next_band;
        int unsigned        span;
        int unsigned        cols [WIN];
        int unsigned        peak;
        band_result_t       pending [$];
        int unsigned        mismatches;

        function new();
            foreach (rows[t, b])
                rows[t][b] = '0;
            foreach (cols[j])
                cols[j] = 0;
            write_row  = 0;
            next_band  = 0;
            span       = MAX_BANDS;
            peak       = 0;
            mismatches = 0;
        endfunction

        function void set_bands(logic [CFG_W-1:0] value);
            span = 32'(value);
        endfunction

        function void push_window(int unsigned idx, int unsigned top, bit last);
            int unsigned  sum;
            int unsigned  val;
            band_result_t r;
            sum = 0;
            for (int unsigned j = 0; j <= top && j < WIN; j++)
                sum += cols[j];
            val = (sum + ROUND) / DIVISOR;
            if (val > LEVEL_MAX)
                val = LEVEL_MAX;
            if (val > peak)
                peak = val;
            r.band      = idx[BAND_W-1:0];
            r.smoothed  = val[LEVEL_W-1:0];
            r.frame_max = peak[LEVEL_W-1:0];
            r.last      = last;
            pending.push_back(r);
        endfunction

        function void note_level(logic [LEVEL_W-1:0] lv);
            int unsigned n;
            int unsigned b;
            int unsigned col;
            bit          last;
            n = (span == 0) ? 1 : ((span > MAX_BANDS) ? MAX_BANDS : span);
            b = (next_band >= MAX_BANDS) ? MAX_BANDS - 1 : next_band;
            if (write_row >= TIME_DEPTH)
                write_row = 0;
            last = (b + 1 >= n);
            if (b == 0)
            begin
                foreach (cols[j])
                    cols[j] = 0;
                peak = 0;
            end
            rows[write_row][b] = lv;
            col = 0;
            for (int t = 0; t < TIME_DEPTH; t++)
                col += rows[t][b];
            for (int j = WIN - 1; j > 0; j--)
                cols[j] = cols[j - 1];
            cols[0] = col;
            if (b >= HALF)
                push_window(b - HALF, WIN - 1, last && HALF == 0);
            if (last)
            begin
                for (int unsigned m = 1; m <= HALF; m++)
                    if (b + m >= HALF)
                        push_window(b + m - HALF, WIN - 1 - m, m == HALF);
                next_band = 0;
                write_row = (write_row + 1) % TIME_DEPTH;
            end
            else
                next_band = b + 1;
        endfunction

        function void check_result(band_result_t got);
            band_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("tb: unexpected result band=%0d smoothed=%0d max=%0d last=%0b",
                             got.band, got.smoothed, got.frame_max, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.band !== want.band || got.smoothed !== want.smoothed ||
                got.frame_max !== want.frame_max || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"tb: mismatch expected band=%0d smoothed=%0d max=%0d last=%0b",
                              " got band=%0d smoothed=%0d max=%0d last=%0b"},
                             want.band, want.smoothed, want.frame_max, want.last,
                             got.band, got.smoothed, got.frame_max, got.last);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   active_bands;
    logic               level_valid;
    logic               level_stall;
    logic [LEVEL_W-1:0] level;
    logic               result_valid;
    logic               result_stall;
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] smoothed;
    logic [LEVEL_W-1:0] frame_max;
    logic               last_of_frame;

    smoother_scoreboard sb;
    bit                 steady;
    bit                 hold_req;
    int                 quiet;

    spectrogram_box_smoother_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .active_bands  (active_bands),
        .level_valid   (level_valid),
        .level_stall   (level_stall),
        .level         (level),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .band          (band),
        .smoothed      (smoothed),
        .frame_max     (frame_max),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stall the output at random, or hold it off for a long stretch on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (steady || !rst_n)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        band_result_t seen;
        if (rst_n && result_valid && !result_stall)
        begin
            seen.band      = band;
            seen.smoothed  = smoothed;
            seen.frame_max = frame_max;
            seen.last      = last_of_frame;
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if ((level_valid && !level_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return LEVEL_MAX;
        if (r < 20)
            return '0;
        return LEVEL_W'($urandom_range(0, LEVEL_MAX));
    endfunction

    task automatic send_level(logic [LEVEL_W-1:0] value);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 35)
        begin
            level_valid <= 1'b0;
            @(negedge clk);
        end
        level_valid <= 1'b1;
        level       <= value;
        @(posedge clk);
        while (level_stall)
            @(posedge clk);
        sb.note_level(value);
    endtask

    // drop valid, drain every expected result, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        level_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_bands(logic [CFG_W-1:0] value);
        settle();
        cfg_valid    <= 1'b1;
        active_bands <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_bands(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          sent;
        int unsigned nb;
        int unsigned nf;

        sb           = new();
        steady       = 1'b0;
        hold_req     = 1'b0;
        quiet        = 0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        active_bands = '0;
        level_valid  = 1'b0;
        level        = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // start a frame under the reset band count
        send_level(LEVEL_MAX);
        send_level('0);
        send_level(LEVEL_MAX);
        send_level(15'd1);

        // widen past the limit, then lower below the current band mid frame
        write_bands('1);
        repeat (3) send_level(pick_level());
        write_bands(10'd2);
        send_level(15'h2AAA);

        write_bands(10'd1);
        repeat (6) send_level(LEVEL_MAX);

        write_bands('0);
        send_level('0);
        send_level(15'h5555);

        write_bands(10'd3);
        send_level(LEVEL_MAX);
        send_level('0);
        send_level(LEVEL_MAX);
        send_level(15'd1);
        send_level(15'd2);
        send_level(15'd3);

        // fill the whole window with full-scale levels
        write_bands(10'd5);
        repeat (5 * TIME_DEPTH) send_level(LEVEL_MAX);

        // one long frame: idle-free start, then a long output hold-off
        write_bands(CFG_W'(LONG_BANDS));
        for (int i = 0; i < LONG_BANDS; i++)
        begin
            steady = (i < 24);
            if (i == 30)
                hold_req = 1'b1;
            send_level(pick_level());
        end
        steady = 1'b0;

        sent = 0;
        while (sent < 16)
        begin
            nb = $urandom_range(1, 8);
            nf = $urandom_range(1, 2);
            write_bands(CFG_W'(nb));
            repeat (nb * nf) send_level(pick_level());
            sent += nb * nf;
        end

        settle();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
